// ----- rtl/sid_pkg.sv -----
package sid_pkg;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam logic [3:0] LAST_DIGIT = 4'd10;
  localparam int unsigned NUM_DIGITS = 11;

  // One queued job for the back end.
  typedef struct packed {
    logic        is_dec;
    logic        empty;
    logic        bad;
    logic [3:0]  first;
    logic [63:0] value;
  } sid_entry_t;

  // Digit k of an id, most significant first; digit 0 holds only 4 bits.
  function automatic logic [5:0] digit_of(input logic [63:0] v, input logic [3:0] k);
    logic [5:0] d;
    case (k)
      4'd0:    d = {2'b00, v[63:60]};
      4'd1:    d = v[59:54];
      4'd2:    d = v[53:48];
      4'd3:    d = v[47:42];
      4'd4:    d = v[41:36];
      4'd5:    d = v[35:30];
      4'd6:    d = v[29:24];
      4'd7:    d = v[23:18];
      4'd8:    d = v[17:12];
      4'd9:    d = v[11:6];
      4'd10:   d = v[5:0];
      default: d = 6'd0;
    endcase
    return d;
  endfunction

  // Alphabet: 0-9, a-z, A-Z, underscore, hyphen.
  function automatic logic [7:0] char_of(input logic [5:0] d);
    logic [7:0] c;
    logic [7:0] dw;
    dw = {2'b00, d};
    if (d < 6'd10) begin
      c = dw + 8'h30;
    end else if (d < 6'd36) begin
      c = dw - 8'd10 + 8'h61;
    end else if (d < 6'd62) begin
      c = dw - 8'd36 + 8'h41;
    end else if (d == 6'd62) begin
      c = 8'h5F;
    end else begin
      c = 8'h2D;
    end
    return c;
  endfunction

endpackage

// ----- rtl/sid_front.sv -----
module sid_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [63:0]       id_value,
  input  logic [7:0]        char_in,
  input  logic              char_last,
  input  logic              q_full,
  output logic              push,
  output sid_pkg::sid_entry_t push_entry
);
  import sid_pkg::*;

  logic [63:0] acc;
  logic        err;
  logic [7:0]  dig8;
  logic [5:0]  dig;
  logic        dig_ok;
  logic [63:0] acc_sum;
  logic [3:0]  first;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (kind == KIND_ENCODE || char_last);

  always_comb begin
    dig8   = 8'd0;
    dig_ok = 1'b0;
    if (char_in == 8'h2D) begin
      dig8   = 8'd63;
      dig_ok = 1'b1;
    end else if (char_in == 8'h5F) begin
      dig8   = 8'd62;
      dig_ok = 1'b1;
    end else if (char_in >= 8'h61) begin
      dig8   = char_in - 8'h61 + 8'd10;
      dig_ok = (char_in <= 8'h7A);
    end else if (char_in >= 8'h41) begin
      dig8   = char_in - 8'h41 + 8'd36;
      dig_ok = (char_in <= 8'h5A);
    end else begin
      dig8   = char_in - 8'h30;
      dig_ok = (char_in >= 8'h30) && (char_in <= 8'h39);
    end
  end

  assign dig     = dig8[5:0];
  assign acc_sum = {acc[57:0], 6'b0} + {58'b0, dig};

  // Lowest index of a nonzero digit; leading zeros are skipped.
  always_comb begin
    first = LAST_DIGIT;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      if (digit_of(id_value, 4'(k)) != 6'd0) begin
        first = 4'(k);
      end
    end
  end

  always_comb begin
    push_entry.is_dec = (kind == KIND_DECODE);
    push_entry.first  = first;
    if (kind == KIND_DECODE) begin
      push_entry.empty = 1'b0;
      push_entry.bad   = err || !dig_ok;
      push_entry.value = acc_sum;
    end else begin
      push_entry.empty = (id_value == 64'd0);
      push_entry.bad   = 1'b0;
      push_entry.value = id_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 64'd0;
      err <= 1'b0;
    end else if (accept && kind == KIND_DECODE) begin
      if (char_last) begin
        acc <= 64'd0;
        err <= 1'b0;
      end else begin
        acc <= acc_sum;
        err <= err || !dig_ok;
      end
    end
  end

endmodule

// ----- rtl/sid_fifo.sv -----
module sid_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sid_pkg::sid_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output sid_pkg::sid_entry_t head,
  output logic                head_valid
);
  import sid_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  sid_entry_t    mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/sid_back.sv -----
module sid_back (
  input  logic                clk,
  input  logic                rst,
  input  sid_pkg::sid_entry_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          char_out,
  output logic                last_char,
  output logic                empty_id,
  output logic [63:0]         decoded_id,
  output logic                decoded_valid,
  output logic                bad_char
);
  import sid_pkg::*;

  logic [3:0] pos;
  logic       pos_active;
  logic       load;
  logic [3:0] d_idx;
  logic       enc_last;

  assign load     = !out_valid || out_ready;
  assign d_idx    = pos_active ? pos : head.first;
  assign enc_last = (d_idx == LAST_DIGIT);
  assign pop      = head_valid && load && (head.is_dec || head.empty || enc_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pos_active <= 1'b0;
      pos        <= 4'd0;
    end else if (head_valid && load) begin
      out_valid <= 1'b1;
      if (head.is_dec) begin
        char_out      <= 8'd0;
        last_char     <= 1'b1;
        empty_id      <= 1'b0;
        decoded_id    <= head.value;
        decoded_valid <= 1'b1;
        bad_char      <= head.bad;
      end else if (head.empty) begin
        char_out      <= 8'd0;
        last_char     <= 1'b1;
        empty_id      <= 1'b1;
        decoded_id    <= 64'd0;
        decoded_valid <= 1'b0;
        bad_char      <= 1'b0;
      end else begin
        char_out      <= char_of(digit_of(head.value, d_idx));
        last_char     <= enc_last;
        empty_id      <= 1'b0;
        decoded_id    <= 64'd0;
        decoded_valid <= 1'b0;
        bad_char      <= 1'b0;
        // advance through the digits, drop the job after the last one
        if (enc_last) begin
          pos_active <= 1'b0;
        end else begin
          pos        <= d_idx + 1'b1;
          pos_active <= 1'b1;
        end
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos_active |-> (pos <= LAST_DIGIT && pos != 4'd0))
    else $error("digit position out of range");
  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst) pop |-> load)
    else $error("job retired while output slot busy");
  a_mid_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_char) |-> (pos_active && head_valid && !head.is_dec))
    else $error("partial id emitted without an active encode job");
  a_last_retires: assert property (@(posedge clk) disable iff (rst)
    (head_valid && load && !head.is_dec && !head.empty && enc_last) |=> !pos_active)
    else $error("encode job not retired on its last digit");

endmodule

// ----- rtl/short_id_base64_codec_core.sv -----
// Short id codec: 64-bit id <-> base-64 text id (0-9, a-z, A-Z, '_', '-').
// Input channel (in_valid/in_ready): kind 0 encodes id_value, kind 1 feeds
// one text character char_in, char_last marking the end of a text id.
// Output channel (out_valid/out_ready): one transaction per encoded
// character, most significant first, last_char on the final one; id zero
// gives a single transaction with empty_id set. A text id gives one
// transaction on its last character carrying decoded_id, decoded_valid and
// bad_char; earlier characters give none.
// Throughput: the front end takes one input transaction per cycle while
// the two-entry job queue has room. The back end retires a decode or zero
// id with one output transaction and an encode with one per emitted
// character (1 to 11), so encodes set the sustained rate.
// An accepted job is written into the job queue, then into the output register.
// Reset clears the decode accumulator, the queue and the output valid flag.
// When the receiver stalls the output register holds, the back end waits,
// and the front end keeps accepting until the queue fills.
module short_id_base64_codec_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] id_value,
  input  logic [7:0]  char_in,
  input  logic        char_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  char_out,
  output logic        last_char,
  output logic        empty_id,
  output logic [63:0] decoded_id,
  output logic        decoded_valid,
  output logic        bad_char
);
  import sid_pkg::*;

  logic       push;
  sid_entry_t push_entry;
  logic       q_full;
  logic       pop;
  sid_entry_t head;
  logic       head_valid;

  sid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .id_value   (id_value),
    .char_in    (char_in),
    .char_last  (char_last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sid_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  sid_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_out      (char_out),
    .last_char     (last_char),
    .empty_id      (empty_id),
    .decoded_id    (decoded_id),
    .decoded_valid (decoded_valid),
    .bad_char      (bad_char)
  );

endmodule

// ----- tb/tb_short_id_base64_codec_core.sv -----
module tb_short_id_base64_codec_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        empty;
    logic [63:0] id;
    logic        dvalid;
    logic        bad;
  } sid_result_t;

  localparam logic [8*64-1:0] ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_-";

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [63:0] id_value;
  logic [7:0]  char_in;
  logic        char_last;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_out;
  logic        last_char;
  logic        empty_id;
  logic [63:0] decoded_id;
  logic        decoded_valid;
  logic        bad_char;

  // Predictor state: decode digits gathered so far and the bad-character latch
  logic [63:0] text_acc;
  logic        text_err;

  sid_result_t awaited_results[$];
  sid_result_t front_result;

  bit in_idle_en;
  bit out_idle_en;
  int n_encodes;
  int n_decodes;
  int n_checked;
  int n_errors;

  short_id_base64_codec_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .id_value     (id_value),
    .char_in      (char_in),
    .char_last    (char_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_out     (char_out),
    .last_char    (last_char),
    .empty_id     (empty_id),
    .decoded_id   (decoded_id),
    .decoded_valid(decoded_valid),
    .bad_char     (bad_char)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] digit_to_char(input logic [5:0] d);
    return ALPHABET[8*(63 - d) +: 8];
  endfunction

  // Out-of-alphabet bytes use the same range arithmetic, wrapped to 8 bits
  function automatic logic [5:0] char_to_digit6(input logic [7:0] c, output logic bad);
    logic [7:0] v;
    bad = 1'b0;
    if (c == 8'h2D) begin
      v = 8'd63;
    end else if (c == 8'h5F) begin
      v = 8'd62;
    end else if (c >= 8'h61) begin
      v = c - 8'h61 + 8'd10;
      bad = (c > 8'h7A);
    end else if (c >= 8'h41) begin
      v = c - 8'h41 + 8'd36;
      bad = (c > 8'h5A);
    end else begin
      v = c - 8'h30;
      bad = (c < 8'h30) || (c > 8'h39);
    end
    return v[5:0];
  endfunction

  task automatic compute_codec_results(input logic k, input logic [63:0] idv,
                                       input logic [7:0] ch, input logic lst);
    sid_result_t r;
    logic [63:0] shifted;
    logic [5:0]  d;
    logic        started;
    logic        bad;
    if (k == sid_pkg::KIND_ENCODE) begin
      n_encodes++;
      if (idv == 64'd0) begin
        r = '{ch: 8'd0, last: 1'b1, empty: 1'b1, id: 64'd0, dvalid: 1'b0, bad: 1'b0};
        awaited_results.insert(awaited_results.size(), r);
      end else begin
        started = 1'b0;
        for (int i = 0; i < 11; i++) begin
          shifted = idv >> (60 - 6 * i);
          d = shifted[5:0];
          if (d != 6'd0) started = 1'b1;
          if (started) begin
            r = '{ch: digit_to_char(d), last: (i == 10), empty: 1'b0, id: 64'd0,
                  dvalid: 1'b0, bad: 1'b0};
            awaited_results.insert(awaited_results.size(), r);
          end
        end
      end
    end else begin
      n_decodes++;
      d = char_to_digit6(ch, bad);
      text_acc = (text_acc << 6) + {58'd0, d};
      if (bad) text_err = 1'b1;
      if (lst) begin
        r = '{ch: 8'd0, last: 1'b1, empty: 1'b0, id: text_acc, dvalid: 1'b1, bad: text_err};
        awaited_results.insert(awaited_results.size(), r);
        text_acc = 64'd0;
        text_err = 1'b0;
      end
    end
  endtask

  // Entered and left at a falling edge; in_valid stays high between back-to-back items
  task automatic send_item(input logic k, input logic [63:0] idv,
                           input logic [7:0] ch, input logic lst);
    while (in_idle_en && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    id_value  <= idv;
    char_in   <= ch;
    char_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_codec_results(k, idv, ch, lst);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic lst);
    send_item(sid_pkg::KIND_DECODE, {$urandom(), $urandom()}, ch, lst);
  endtask

  task automatic send_id(input logic [63:0] idv);
    send_item(sid_pkg::KIND_ENCODE, idv, 8'($urandom()), 1'($urandom()));
  endtask

  task automatic compare_field(input string name, input logic [63:0] e,
                               input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      n_errors++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= out_idle_en ? ($urandom_range(99) >= 21) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual char %h id %h",
                 $time, char_out, decoded_id);
        n_errors++;
      end else begin
        front_result = awaited_results.pop_front();
        n_checked++;
        compare_field("char_out", front_result.ch, char_out);
        compare_field("last_char", front_result.last, last_char);
        compare_field("empty_id", front_result.empty, empty_id);
        compare_field("decoded_id", front_result.id, decoded_id);
        compare_field("decoded_valid", front_result.dvalid, decoded_valid);
        compare_field("bad_char", front_result.bad, bad_char);
      end
    end
  end

  task automatic test_encode_edges();
    send_id(64'd0);
    send_id(64'd62);
    send_id(64'hFFFF_FFFF_FFFF_FFFF);
    send_id(64'h1000_0000_0000_0000);
    send_id(64'h0FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_decode_edges();
    send_char("0", 1'b1);
    send_char("z", 1'b0);
    send_char("A", 1'b0);
    send_char("_", 1'b0);
    send_char("-", 1'b1);
    // bad byte mid-text must still flag the finished id
    send_char(8'hFF, 1'b0);
    send_char("[", 1'b1);
  endtask

  // Twelve characters wrap the accumulator; an encode in the middle leaves it alone
  task automatic test_long_text_interleaved();
    for (int i = 0; i < 12; i++) begin
      if (i == 6) send_id(64'd63);
      send_char(digit_to_char(6'(63 - 5 * i)), i == 11);
    end
  endtask

  task automatic test_random_mix();
    int n_items;
    int len;
    int sel;
    logic [63:0] idv;
    logic [7:0]  ch;
    n_items = 0;
    while (n_items < 125) begin
      // hold both sides busy for a long stretch in the middle
      in_idle_en  = !(n_items >= 40 && n_items < 85);
      out_idle_en = in_idle_en;
      sel = $urandom_range(99);
      if (sel < 45) begin
        idv = {$urandom(), $urandom()};
        idv = ($urandom_range(19) == 0) ? 64'd0 : idv >> $urandom_range(63);
        send_id(idv);
        n_items++;
      end else if (sel < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 14) : $urandom_range(1, 11);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(11) == 0) ? 8'($urandom()) : digit_to_char(6'($urandom()));
          send_char(ch, i == len - 1);
          n_items++;
        end
      end else begin
        send_item(1'($urandom()), {$urandom(), $urandom()}, 8'($urandom()),
                  1'($urandom()));
        n_items++;
      end
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = sid_pkg::KIND_ENCODE;
    id_value    = 64'd0;
    char_in     = 8'd0;
    char_last   = 1'b0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    text_acc    = 64'd0;
    text_err    = 1'b0;
    n_encodes   = 0;
    n_decodes   = 0;
    n_checked   = 0;
    n_errors    = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_encode_edges();
    test_decode_edges();
    test_long_text_interleaved();
    test_random_mix();

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d encode and %0d decode transactions, %0d results checked.",
             n_encodes, n_decodes, n_checked);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still awaited", awaited_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- short_id_base64_codec_core.f -----
rtl/sid_pkg.sv
rtl/sid_front.sv
rtl/sid_fifo.sv
rtl/sid_back.sv
rtl/short_id_base64_codec_core.sv
tb/tb_short_id_base64_codec_core.sv
